/* sv/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window maximum unit
// Holds the register map, the configuration widths and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Configuration register width and APB geometry.
    localparam int CFG_WIDTH  = 7;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Word index of the window size register (byte address 4 * index).
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

    // Reset value of the window size register.
    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;      // latch a new item and advance the position
        logic rd_head;   // read the entry at the head of the deque
        logic rd_tail;   // read the entry just before the tail
        logic pop_head;  // retire the head entry
        logic pop_tail;  // drop the last entry
        logic append;    // write the new sample at the tail
        logic load_out;  // move the head value into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic occ_zero;   // the deque holds no entry
        logic expired;    // the entry just read has left the window
        logic smaller;    // the entry just read is below the new sample
        logic full_next;  // the window is full once this sample is counted
    } t_status;

endpackage

/* sv/swm_if.sv */
// ----------------------------------------------------------------------------
// swm_in_if / swm_out_if: item channels of the sliding window maximum unit
// Valid and ready handshake; an item moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface swm_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_of_sequence;

    modport source (output valid, output sample, output start_of_sequence, input ready);
    modport sink   (input valid, input sample, input start_of_sequence, output ready);
endinterface

interface swm_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

/* sv/swm_datapath.sv */
// ----------------------------------------------------------------------------
// swm_datapath: deque storage, pointers and counters
// Holds the candidate memory with one registered read port and one write
// port, the ring pointers, the occupancy and position counters and the
// output register, and reports the compare results to the controller.
// ----------------------------------------------------------------------------
module swm_datapath #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [swm_pkg::CFG_WIDTH-1:0]       i_window_size,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_sample,
    input  logic                                i_start_of_sequence,
    input  swm_pkg::t_cmd                       i_cmd,
    output swm_pkg::t_status                    o_status,
    output logic signed [SAMPLE_WIDTH-1:0]      o_window_max
);
    import swm_pkg::*;

    // Counts hold 0..WINDOW_MAX; positions wrap; ages never exceed WINDOW_MAX.
    localparam int PW = $clog2(WINDOW_MAX + 1);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = (PW > CFG_WIDTH) ? PW : CFG_WIDTH;
    localparam int EW = SAMPLE_WIDTH + PW;

    logic [EW-1:0]                  r_mem [WINDOW_MAX];
    logic [EW-1:0]                  r_rd;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;
    logic signed [SAMPLE_WIDTH-1:0] r_out;
    logic [AW-1:0]                  r_head;
    logic [AW-1:0]                  r_tail;
    logic [PW-1:0]                  r_occ;
    logic [PW-1:0]                  r_pos;
    logic [PW-1:0]                  r_seen;

    logic [CW-1:0]                  w_ext;
    logic [PW-1:0]                  k_eff;
    logic [PW-1:0]                  n_seen;
    logic [PW-1:0]                  age;
    logic signed [SAMPLE_WIDTH-1:0] rd_val;
    logic [PW-1:0]                  rd_pos;
    logic [AW-1:0]                  tail_prev;

    // Ring index steps.
    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == AW'(WINDOW_MAX - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
        return (p == '0) ? AW'(WINDOW_MAX - 1) : p - AW'(1);
    endfunction

    // Effective window: zero counts as one, large values saturate.
    assign w_ext = CW'(i_window_size);

    always_comb begin
        if (w_ext == '0) begin
            k_eff = PW'(1);
        end else if (w_ext > CW'(WINDOW_MAX)) begin
            k_eff = PW'(WINDOW_MAX);
        end else begin
            k_eff = PW'(w_ext);
        end
    end

    // Compare results on the entry held in the read register.
    assign rd_val    = r_rd[EW-1:PW];
    assign rd_pos    = r_rd[PW-1:0];
    assign age       = r_pos - rd_pos;
    assign tail_prev = ring_prev(r_tail);
    assign n_seen    = (r_seen == PW'(WINDOW_MAX)) ? r_seen : r_seen + PW'(1);

    assign o_status.occ_zero  = (r_occ == '0);
    assign o_status.expired   = (age >= k_eff);
    assign o_status.smaller   = (rd_val < r_sample);
    assign o_status.full_next = (n_seen >= k_eff);

    assign o_window_max = r_out;

    // Pointers and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
            r_pos  <= '0;
            r_seen <= '0;
        end else begin
            priority if (i_cmd.take) begin
                if (i_start_of_sequence) begin
                    r_head <= '0;
                    r_tail <= '0;
                    r_occ  <= '0;
                    r_seen <= '0;
                    r_pos  <= PW'(1);
                end else begin
                    r_pos  <= r_pos + PW'(1);
                end
            end else if (i_cmd.pop_head) begin
                r_head <= ring_next(r_head);
                r_occ  <= r_occ - PW'(1);
            end else if (i_cmd.pop_tail) begin
                r_tail <= tail_prev;
                r_occ  <= r_occ - PW'(1);
            end else if (i_cmd.append) begin
                r_tail <= ring_next(r_tail);
                r_occ  <= r_occ + PW'(1);
                r_seen <= n_seen;
            end
        end
    end

    // Candidate memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[r_tail] <= {r_sample, r_pos};
        end
        if (i_cmd.rd_head) begin
            r_rd <= r_mem[r_head];
        end else if (i_cmd.rd_tail) begin
            r_rd <= r_mem[tail_prev];
        end
    end

    // Item payload and output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_sample;
        end
        if (i_cmd.load_out) begin
            r_out <= rd_val;
        end
    end

endmodule

/* sv/swm_controller.sv */
// ----------------------------------------------------------------------------
// swm_controller: sequencer of the sliding window maximum unit
// Walks one item through head retirement, tail removal, append and, once the
// window fills, emission, one memory access at a time; owns both handshakes.
// ----------------------------------------------------------------------------
module swm_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  swm_pkg::t_status i_status,
    output swm_pkg::t_cmd    o_cmd
);
    import swm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_TAIL_RD,
        S_TAIL_CHK,
        S_APPEND,
        S_OUT_RD,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Command decode from the current state and the datapath status.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:     o_cmd.take     = i_in_valid;
            S_HEAD_RD:  o_cmd.rd_head  = !i_status.occ_zero;
            S_HEAD_CHK: o_cmd.pop_head = i_status.expired;
            S_TAIL_RD:  o_cmd.rd_tail  = !i_status.occ_zero;
            S_TAIL_CHK: o_cmd.pop_tail = i_status.smaller;
            S_APPEND:   o_cmd.append   = 1'b1;
            S_OUT_RD:   o_cmd.rd_head  = 1'b1;
            S_EMIT:     o_cmd.load_out = out_free;
            default:    o_cmd          = '0;
        endcase
    end

    // State register and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD: begin
                    r_state <= i_status.occ_zero ? S_TAIL_RD : S_HEAD_CHK;
                end
                S_HEAD_CHK: begin
                    r_state <= i_status.expired ? S_HEAD_RD : S_TAIL_RD;
                end
                S_TAIL_RD: begin
                    r_state <= i_status.occ_zero ? S_APPEND : S_TAIL_CHK;
                end
                S_TAIL_CHK: begin
                    r_state <= i_status.smaller ? S_TAIL_RD : S_APPEND;
                end
                S_APPEND: begin
                    r_state <= i_status.full_next ? S_OUT_RD : S_IDLE;
                end
                S_OUT_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/sliding_window_maximum_unit.sv */
// ----------------------------------------------------------------------------
// One item is in flight at a time: a new item is accepted only once the
//   last has finished, and the one read port of the candidate memory
//   serves each compare step in turn.
// Reset: synchronous, active low; empties the deque, clears the counters and
//   sets the window size to one. The candidate memory itself is not cleared.
// ----------------------------------------------------------------------------
// sliding_window_maximum_unit: running maximum over the last k samples
// Monotonic deque in a ring memory, sequenced by a controller, with an APB
// register for the window size.
// ----------------------------------------------------------------------------
module sliding_window_maximum_unit #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    swm_in_if.sink                          i_in,
    swm_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [swm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [swm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import swm_pkg::*;

    logic [CFG_WIDTH-1:0] r_window_size;
    logic                 reg_sel;
    logic                 cfg_write;
    t_cmd                 cmd;
    t_status              status;

    // Configuration register; the word index is the third address bit.
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == REG_WINDOW_SIZE);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign prdata    = reg_sel ? APB_DATA_W'(r_window_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RESET;
        end else if (cfg_write) begin
            r_window_size <= pwdata[CFG_WIDTH-1:0];
        end
    end

    // Sequencer.
    swm_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Deque storage and arithmetic.
    swm_datapath #(
        .WINDOW_MAX   (WINDOW_MAX),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_window_size       (r_window_size),
        .i_sample            (i_in.sample),
        .i_start_of_sequence (i_in.start_of_sequence),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_window_max        (o_out.window_max)
    );

    // An entry is never popped from an empty deque.
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.pop_head || cmd.pop_tail) |-> !status.occ_zero)
        else $error("pop issued on an empty deque");

    // Only one item is in flight: ready drops after an acceptance.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second item accepted while one is in flight");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out.valid || o_out.ready))
        else $error("pending result overwritten");

endmodule
